>>> rtl/assert_macros.svh
// Assertion macros for checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("check failed");

// Implication checked in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("check failed");

`endif

>>> rtl/q2e_pkg.sv
// -----------------------------------------------------------------------------
// q2e_pkg
// Shared constants, ROM and helpers for the quaternion to Euler angle core.
// -----------------------------------------------------------------------------
package q2e_pkg;

	localparam int DEF_CORDIC_STEPS = 14;
	localparam int ROM_SIZE = 24;
	localparam int CW = 34;

	typedef enum logic [1:0] {
		POLE_NONE = 2'd0,
		POLE_POS  = 2'd1,
		POLE_NEG  = 2'd2
	} pole_t;

	// Arctangent of 2^-i at scale 2^30.
	function automatic logic signed [31:0] atan_rom(input int i);
		logic signed [31:0] r;
		case (i)
			0: r = 32'sd843314857;
			1: r = 32'sd497837829;
			2: r = 32'sd263043837;
			3: r = 32'sd133525159;
			4: r = 32'sd67021687;
			5: r = 32'sd33543516;
			6: r = 32'sd16775851;
			7: r = 32'sd8388437;
			8: r = 32'sd4194283;
			9: r = 32'sd2097149;
			10: r = 32'sd1048576;
			11: r = 32'sd524288;
			12: r = 32'sd262144;
			13: r = 32'sd131072;
			14: r = 32'sd65536;
			15: r = 32'sd32768;
			16: r = 32'sd16384;
			17: r = 32'sd8192;
			18: r = 32'sd4096;
			19: r = 32'sd2048;
			20: r = 32'sd1024;
			21: r = 32'sd512;
			22: r = 32'sd256;
			23: r = 32'sd128;
			default: r = 32'sd0;
		endcase
		return r;
	endfunction

	// Clamp a wide value to 16-bit signed range.
	function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
		logic signed [15:0] r;
		if (v > 20'sd32767) r = 16'sd32767;
		else if (v < -20'sd32768) r = -16'sd32768;
		else r = v[15:0];
		return r;
	endfunction

endpackage

>>> rtl/quaternion_to_euler_zyx_core.sv
// -----------------------------------------------------------------------------
// quaternion_to_euler_zyx_core
// Quaternion (Q2.14) to Z-Y-X Euler angles (Q3.13) through a pipelined CORDIC.
// -----------------------------------------------------------------------------
// Channel   Direction  Handshake             Payload
// command   in         start & !busy         quat_w, quat_x, quat_y, quat_z
// result    out        done strobe, 1 cycle  roll/pitch/yaw_angle, pole_case
//
// One item enters per cycle; busy is held low.
// CORDIC_STEPS is capped at 24. The stages in order are the products, matrix terms,
// square-root setup, 15 square-root stages, the CORDIC pre-rotation, one stage
// per CORDIC step and the output register.
// Reset clears the valid bits only; payload registers hold no reset.
// The receiver cannot stall, so the pipeline never stops.
module quaternion_to_euler_zyx_core
	import q2e_pkg::*;
#(
	parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic signed [15:0] quat_w,
	input  logic signed [15:0] quat_x,
	input  logic signed [15:0] quat_y,
	input  logic signed [15:0] quat_z,
	output logic               done,
	output logic signed [15:0] roll_angle,
	output logic signed [14:0] pitch_angle,
	output logic signed [15:0] yaw_angle,
	output logic [1:0]         pole_case
);

	localparam int NIT = (CORDIC_STEPS < ROM_SIZE) ? CORDIC_STEPS : ROM_SIZE;
	localparam int NSQ = 15;
	localparam int NST = NSQ + NIT + 4;

	assign busy = 1'b0;

	// Valid bits, one per stage.
	logic [NST:0] vld_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_q <= '0;
		else vld_q <= {vld_q[NST-1:0], start};
	end

	// Stage 1: nine products.
	logic signed [15:0] p_s1 [9];
	function automatic logic signed [15:0] prod(input logic signed [15:0] a,
			input logic signed [15:0] b);
		logic signed [33:0] t;
		t = (34'(a) * 34'(b)) * 2 + 34'sd8192;
		t = t >>> 14;
		if (t > 34'sd32767) return 16'sd32767;
		if (t < -34'sd32768) return -16'sd32768;
		return t[15:0];
	endfunction
	always_ff @(posedge clk) begin
		p_s1[0] <= prod(quat_x, quat_w);
		p_s1[1] <= prod(quat_y, quat_w);
		p_s1[2] <= prod(quat_z, quat_w);
		p_s1[3] <= prod(quat_x, quat_x);
		p_s1[4] <= prod(quat_y, quat_x);
		p_s1[5] <= prod(quat_z, quat_x);
		p_s1[6] <= prod(quat_y, quat_y);
		p_s1[7] <= prod(quat_z, quat_y);
		p_s1[8] <= prod(quat_z, quat_z);
	end

	// Stage 2: matrix terms and branch choice.
	// The yaw operands carry 17 bits, since negating a pole term may reach +32768.
	logic signed [16:0] ya_s2, xa_s2;
	logic signed [15:0] yb_s2, xb_s2, r13_s2;
	pole_t pole_s2;
	always_ff @(posedge clk) begin
		logic signed [15:0] r11, r12, r13, r23, r33, r21, r31;
		r11 = sat16(20'sd16384 - (20'(p_s1[6]) + 20'(p_s1[8])));
		r12 = sat16(20'(p_s1[4]) + 20'(p_s1[2]));
		r13 = sat16(20'(p_s1[5]) - 20'(p_s1[1]));
		r23 = sat16(20'(p_s1[7]) + 20'(p_s1[0]));
		r33 = sat16(20'sd16384 - (20'(p_s1[3]) + 20'(p_s1[6])));
		r21 = sat16(20'(p_s1[4]) - 20'(p_s1[2]));
		r31 = sat16(20'(p_s1[5]) + 20'(p_s1[1]));
		r13_s2 <= r13;
		if (r13 > -16'sd16384 && r13 < 16'sd16384) begin
			pole_s2 <= POLE_NONE;
			ya_s2 <= 17'(r12); xa_s2 <= 17'(r11); yb_s2 <= r23; xb_s2 <= r33;
		end else if (r13 <= -16'sd16384) begin
			pole_s2 <= POLE_POS;
			ya_s2 <= 17'(r21); xa_s2 <= 17'(r31); yb_s2 <= '0; xb_s2 <= '0;
		end else begin
			pole_s2 <= POLE_NEG;
			ya_s2 <= -17'(r21); xa_s2 <= -17'(r31);
			yb_s2 <= '0; xb_s2 <= '0;
		end
	end

	// Square-root stages: one result bit per stage for 2^28 - r13^2.
	logic [28:0] rem_s [NSQ+1];
	logic [14:0] root_s [NSQ+1];
	logic signed [16:0] sya_s [NSQ+1], sxa_s [NSQ+1];
	logic signed [15:0] syb_s [NSQ+1], sxb_s [NSQ+1];
	logic signed [15:0] sr_s [NSQ+1];
	pole_t spl_s [NSQ+1];
	always_ff @(posedge clk) begin
		logic signed [31:0] sq;
		sq = 32'(r13_s2) * 32'(r13_s2);
		rem_s[0] <= 29'(32'sh1000_0000 - sq);
		root_s[0] <= '0;
		sya_s[0] <= ya_s2; sxa_s[0] <= xa_s2; syb_s[0] <= yb_s2; sxb_s[0] <= xb_s2;
		sr_s[0] <= r13_s2; spl_s[0] <= pole_s2;
	end
	for (genvar k = 0; k < NSQ; k++) begin : g_sq
		localparam int B = NSQ - 1 - k;
		always_ff @(posedge clk) begin
			logic [29:0] trial;
			trial = ({15'd0, root_s[k]} << (B + 1)) + (30'd1 << (2 * B));
			if ({1'b0, rem_s[k]} >= trial) begin
				rem_s[k+1] <= 29'({1'b0, rem_s[k]} - trial);
				root_s[k+1] <= root_s[k] | 15'(1 << B);
			end else begin
				rem_s[k+1] <= rem_s[k];
				root_s[k+1] <= root_s[k];
			end
			sya_s[k+1] <= sya_s[k]; sxa_s[k+1] <= sxa_s[k];
			syb_s[k+1] <= syb_s[k]; sxb_s[k+1] <= sxb_s[k];
			sr_s[k+1] <= sr_s[k]; spl_s[k+1] <= spl_s[k];
		end
	end

	// CORDIC lanes: 0 pitch, 1 yaw, 2 roll. Pre-rotation stage, then iterations.
	logic signed [CW-1:0] cx_s [3][NIT+1];
	logic signed [CW-1:0] cy_s [3][NIT+1];
	logic signed [32:0]   cz_s [3][NIT+1];
	logic [2:0]           zr_s [NIT+1];
	pole_t                cpl_s [NIT+1];
	always_ff @(posedge clk) begin
		logic signed [16:0] ly [3];
		logic signed [16:0] lx [3];
		ly[0] = -17'(sr_s[NSQ]); lx[0] = signed'({2'b0, root_s[NSQ]});
		ly[1] = sya_s[NSQ]; lx[1] = sxa_s[NSQ];
		ly[2] = 17'(syb_s[NSQ]); lx[2] = 17'(sxb_s[NSQ]);
		for (int l = 0; l < 3; l++) begin
			zr_s[0][l] <= (lx[l] == 0) && (ly[l] == 0);
			if (lx[l] < 0) begin
				if (ly[l] >= 0) begin
					cx_s[l][0] <= CW'(ly[l]) <<< 14;
					cy_s[l][0] <= -(CW'(lx[l]) <<< 14);
					cz_s[l][0] <= 33'sd1686629713;
				end else begin
					cx_s[l][0] <= -(CW'(ly[l]) <<< 14);
					cy_s[l][0] <= CW'(lx[l]) <<< 14;
					cz_s[l][0] <= -33'sd1686629713;
				end
			end else begin
				cx_s[l][0] <= CW'(lx[l]) <<< 14;
				cy_s[l][0] <= CW'(ly[l]) <<< 14;
				cz_s[l][0] <= '0;
			end
		end
		cpl_s[0] <= spl_s[NSQ];
	end
	for (genvar i = 0; i < NIT; i++) begin : g_it
		always_ff @(posedge clk) begin
			for (int l = 0; l < 3; l++) begin
				if (cy_s[l][i] >= 0) begin
					cx_s[l][i+1] <= cx_s[l][i] + (cy_s[l][i] >>> i);
					cy_s[l][i+1] <= cy_s[l][i] - (cx_s[l][i] >>> i);
					cz_s[l][i+1] <= cz_s[l][i] + 33'(atan_rom(i));
				end else begin
					cx_s[l][i+1] <= cx_s[l][i] - (cy_s[l][i] >>> i);
					cy_s[l][i+1] <= cy_s[l][i] + (cx_s[l][i] >>> i);
					cz_s[l][i+1] <= cz_s[l][i] - 33'(atan_rom(i));
				end
			end
			zr_s[i+1] <= zr_s[i];
			cpl_s[i+1] <= cpl_s[i];
		end
	end

	// Final stage: scale to Q3.13, clamp and pick the branch outputs.
	function automatic logic signed [15:0] to_q13(input logic signed [32:0] a,
			input logic zero, input logic signed [15:0] lim);
		logic signed [33:0] t;
		t = (34'(a) + 34'sd65536) >>> 17;
		if (zero) return '0;
		if (t > 34'(lim)) return lim;
		if (t < -34'(lim)) return -lim;
		return t[15:0];
	endfunction
	logic signed [15:0] roll_q, yaw_q;
	logic signed [14:0] pitch_q;
	logic [1:0] pole_q;
	always_ff @(posedge clk) begin
		logic signed [15:0] yv;
		yv = to_q13(cz_s[1][NIT], zr_s[NIT][1], 16'sd25736);
		unique case (cpl_s[NIT])
			POLE_POS: begin
				pitch_q <= 15'sd12868; roll_q <= '0; yaw_q <= -yv;
			end
			POLE_NEG: begin
				pitch_q <= -15'sd12868; roll_q <= '0; yaw_q <= yv;
			end
			default: begin
				pitch_q <= 15'(to_q13(cz_s[0][NIT], zr_s[NIT][0], 16'sd12868));
				roll_q <= to_q13(cz_s[2][NIT], zr_s[NIT][2], 16'sd25736);
				yaw_q <= yv;
			end
		endcase
		pole_q <= cpl_s[NIT];
	end

	assign done = vld_q[NST];
	assign roll_angle = roll_q;
	assign pitch_angle = pitch_q;
	assign yaw_angle = yaw_q;
	assign pole_case = pole_q;

endmodule

>>> rtl/q2e_checker.sv
// -----------------------------------------------------------------------------
// q2e_checker
// Port-level checks on the quaternion to Euler angle core.
// -----------------------------------------------------------------------------
`include "assert_macros.svh"
module q2e_checker
	import q2e_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               busy,
	input logic               done,
	input logic signed [15:0] roll_angle,
	input logic signed [14:0] pitch_angle,
	input logic [1:0]         pole_case
);
	`CHK_IMPL(a_never_busy, clk, arst_n, 1'b1, !busy)
	`CHK_IMPL(a_pole_code, clk, arst_n, done, pole_case != 2'd3)
	`CHK_IMPL(a_pole_roll, clk, arst_n, done && pole_case != POLE_NONE, roll_angle == 16'sd0)
	`CHK_IMPL(a_pole_pitch, clk, arst_n, done && pole_case == POLE_POS,
		pitch_angle == 15'sd12868)
endmodule

bind quaternion_to_euler_zyx_core q2e_checker u_q2e_checker (
	.clk(clk), .arst_n(arst_n), .busy(busy), .done(done),
	.roll_angle(roll_angle), .pitch_angle(pitch_angle), .pole_case(pole_case)
);
